@@ sv/bso_pkg.sv @@
package bso_pkg;

    // Result kinds reported in tuser
    localparam logic [1:0] TOUCH_NONE = 2'd0;
    localparam logic [1:0] TOUCH_DIM  = 2'd1;
    localparam logic [1:0] TOUCH_DOT  = 2'd2;

    localparam logic [7:0] DIM_AMOUNT   = 8'd64;
    localparam logic [7:0] CHROMA_MID   = 8'd128;
    localparam logic [7:0] CHROMA_HIGH  = 8'd224;
    localparam logic [7:0] CHROMA_LOW   = 8'd32;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [15:0] anim_step;
        logic [1:0]  color_sel;
        logic [9:0]  pixel_col;
        logic [9:0]  pixel_row;
        logic [7:0]  luma_a;
        logic [7:0]  chroma_u;
        logic [7:0]  luma_b;
        logic [7:0]  chroma_v;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] luma_a;
        logic [7:0] chroma_u;
        logic [7:0] luma_b;
        logic [7:0] chroma_v;
        logic [1:0] touched;
    } t_pix_out;

    typedef struct packed {
        logic [1:0] gx;
        logic [1:0] gy;
    } t_grid;

    // Dot ring layout: 0 1 2 / 7 . 3 / 6 5 4
    function automatic t_grid dot_grid(input logic [2:0] d);
        t_grid g;
        unique case (d)
            3'd0:    g = '{gx: 2'd0, gy: 2'd0};
            3'd1:    g = '{gx: 2'd1, gy: 2'd0};
            3'd2:    g = '{gx: 2'd2, gy: 2'd0};
            3'd3:    g = '{gx: 2'd2, gy: 2'd1};
            3'd4:    g = '{gx: 2'd2, gy: 2'd2};
            3'd5:    g = '{gx: 2'd1, gy: 2'd2};
            3'd6:    g = '{gx: 2'd0, gy: 2'd2};
            default: g = '{gx: 2'd0, gy: 2'd1};
        endcase
        return g;
    endfunction

endpackage

@@ sv/bso_calc.sv @@
module bso_calc import bso_pkg::*; #(
    parameter int SPOT_SIZE = 32
) (
    input  logic [9:0] i_width,
    input  logic [9:0] i_height,
    input  t_pix_in    i_pix,
    output t_pix_out   o_pix
);

    localparam int DOT_SIZE = SPOT_SIZE / 4;
    localparam int DOT_SEP  = (SPOT_SIZE - DOT_SIZE) / 2;
    localparam int REACH    = SPOT_SIZE / 2 + DOT_SIZE;

    logic               small_scr;
    logic signed [11:0] col_s, row_s, mx, my, dx, dy, sum_d;
    logic               dim_hit;
    logic               cs;
    logic [2:0]         dot_idx;
    t_grid              grid;
    logic [10:0]        base_x, base_y;
    logic signed [11:0] off_x, off_y, sx, sy, ox, oy;
    logic               dot_hit;
    logic signed [9:0]  a1, a2, yy, lum_a, lum_b;
    logic [7:0]         dim_a, dim_b;

    assign small_scr = (i_width < 10'(SPOT_SIZE)) || (i_height < 10'(SPOT_SIZE));

    // Dim front distance from screen centre
    assign col_s = $signed({2'b00, i_pix.pixel_col});
    assign row_s = $signed({2'b00, i_pix.pixel_row});
    assign mx    = $signed({3'b000, i_width[9:1]});
    assign my    = $signed({3'b000, i_height[9:1]});
    assign dx    = (col_s >= mx) ? (col_s - mx) : (mx - 12'sd2 - col_s);
    assign dy    = (row_s >= my) ? (row_s - my) : (my - 12'sd1 - row_s);
    assign sum_d = (dx >>> 1) + dy;

    assign dim_hit = (i_pix.anim_step < 16'(2 * REACH)) && (dx >= 12'sd0) && !dx[0]
                     && (dx < 12'(REACH)) && (dy < 12'(REACH))
                     && (sum_d == $signed(i_pix.anim_step[11:0]));

    // Dot position for this step
    assign cs      = i_pix.anim_step[1];
    assign dot_idx = {i_pix.anim_step[4] ^ cs, i_pix.anim_step[3:2]};
    assign grid    = dot_grid(dot_idx);
    assign base_x  = ({1'b0, i_width}  - 11'(SPOT_SIZE)) >> 1;
    assign base_y  = ({1'b0, i_height} - 11'(SPOT_SIZE)) >> 1;

    always_comb begin
        unique case (grid.gx)
            2'd0:    off_x = 12'sd0;
            2'd1:    off_x = 12'(DOT_SEP);
            default: off_x = 12'(2 * DOT_SEP);
        endcase
        unique case (grid.gy)
            2'd0:    off_y = 12'sd0;
            2'd1:    off_y = 12'(DOT_SEP);
            default: off_y = 12'(2 * DOT_SEP);
        endcase
    end

    assign sx = $signed({1'b0, base_x}) + off_x;
    assign sy = $signed({1'b0, base_y}) + off_y;
    assign ox = col_s - sx;
    assign oy = row_s - sy;

    assign dot_hit = !i_pix.anim_step[0] && (ox >= 12'sd0) && (ox < 12'(DOT_SIZE)) && !ox[0]
                     && (oy >= 12'sd0) && (oy < 12'(DOT_SIZE));

    // Dot luma gradient: edge columns and top/bottom rows
    always_comb begin
        a1 = 10'sd0;
        a2 = 10'sd0;
        yy = 10'sd0;
        if (ox == 12'sd0) begin
            a1 = 10'sd31;
            a2 = 10'sd16;
        end
        if (ox + 12'sd2 >= 12'(DOT_SIZE)) begin
            a1 = -10'sd16;
            a2 = -10'sd31;
        end
        if (oy < 12'sd3) begin
            yy = yy + 10'(32 * (3 - oy));
        end
        if (oy + 12'sd3 >= 12'(DOT_SIZE)) begin
            yy = yy - 10'(32 * (oy + 12'sd4 - 12'(DOT_SIZE)));
        end
    end

    assign lum_a = 10'sd128 + a1 + yy;
    assign lum_b = 10'sd128 + a2 + yy;

    assign dim_a = (i_pix.luma_a > DIM_AMOUNT) ? (i_pix.luma_a - DIM_AMOUNT) : 8'd0;
    assign dim_b = (i_pix.luma_b > DIM_AMOUNT) ? (i_pix.luma_b - DIM_AMOUNT) : 8'd0;

    // Dot wins over dim, small screen passes everything
    always_comb begin
        o_pix.luma_a   = i_pix.luma_a;
        o_pix.chroma_u = i_pix.chroma_u;
        o_pix.luma_b   = i_pix.luma_b;
        o_pix.chroma_v = i_pix.chroma_v;
        o_pix.touched  = TOUCH_NONE;
        if (!small_scr) begin
            if (dim_hit) begin
                o_pix.luma_a  = dim_a;
                o_pix.luma_b  = dim_b;
                o_pix.touched = TOUCH_DIM;
            end
            if (dot_hit) begin
                o_pix.luma_a  = lum_a[7:0];
                o_pix.luma_b  = lum_b[7:0];
                o_pix.touched = TOUCH_DOT;
                if (cs) begin
                    o_pix.chroma_u = i_pix.color_sel[0] ? CHROMA_HIGH : CHROMA_LOW;
                    o_pix.chroma_v = i_pix.color_sel[1] ? CHROMA_HIGH : CHROMA_LOW;
                end else begin
                    o_pix.chroma_u = CHROMA_MID;
                    o_pix.chroma_v = CHROMA_MID;
                end
            end
        end
    end

endmodule

@@ sv/busy_spinner_overlay_unit.sv @@
// Path from input accept to result valid: input register, then result register.
// Throughput: one pixel pair per cycle unless the result side stalls; the whole decision is one combinational pass
// between the two registers, and each stage holds its item only while the stage after
// it is full and stalled.
// Reset (synchronous, active low) empties both stages and clears screen width and
// height to 0, so every pair passes unchanged until both are written with at least SPOT_SIZE.
module busy_spinner_overlay_unit import bso_pkg::*; #(
    parameter int SPOT_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    // Input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: anim_step[15:0], pixel_col[25:16], pixel_row[35:26], in_luma_a[43:36],
    //        in_chroma_u[51:44], in_luma_b[59:52], in_chroma_v[67:60], zero[71:68]
    input  logic [71:0] i_s_tdata,
    // tuser: color_sel[1:0]
    input  logic [1:0]  i_s_tuser,
    // Result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: out_luma_a[7:0], out_chroma_u[15:8], out_luma_b[23:16], out_chroma_v[31:24]
    output logic [31:0] o_m_tdata,
    // tuser: touched[1:0]
    output logic [1:0]  o_m_tuser
);

    logic [9:0] r_width, r_height;
    logic       r_in_valid, r_out_valid;
    t_pix_in    r_in_pix, n_in_pix;
    t_pix_out   r_out_pix, n_out_pix;
    logic       out_adv, in_adv;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == CFG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Advance the pipeline when the next stage is free or draining
    assign out_adv    = !r_out_valid || i_m_tready;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_s_tready = in_adv;

    assign n_in_pix.anim_step = i_s_tdata[15:0];
    assign n_in_pix.color_sel = i_s_tuser;
    assign n_in_pix.pixel_col = i_s_tdata[25:16];
    assign n_in_pix.pixel_row = i_s_tdata[35:26];
    assign n_in_pix.luma_a    = i_s_tdata[43:36];
    assign n_in_pix.chroma_u  = i_s_tdata[51:44];
    assign n_in_pix.luma_b    = i_s_tdata[59:52];
    assign n_in_pix.chroma_v  = i_s_tdata[67:60];

    bso_calc #(
        .SPOT_SIZE (SPOT_SIZE)
    ) u_calc (
        .i_width  (r_width),
        .i_height (r_height),
        .i_pix    (r_in_pix),
        .o_pix    (n_out_pix)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_s_tvalid) begin
            r_in_pix <= n_in_pix;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out_pix <= n_out_pix;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_pix.chroma_v, r_out_pix.luma_b,
                         r_out_pix.chroma_u, r_out_pix.luma_a};
    assign o_m_tuser  = r_out_pix.touched;

endmodule
